// ===== sv/llpb_pkg.sv =====
// Shared types, command codes and constants for the least-loaded port balancer.
`timescale 1ns / 1ps

package llpb_pkg;

    localparam int PORT_SLOTS_DEF = 16;
    localparam int PORT_W         = 16;
    localparam int CNT_W          = 16;
    localparam int FUNC_W         = 3;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 24;

    localparam logic [CNT_W-1:0]  GAP_RESET = 16'd5;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;

    localparam logic [FUNC_W-1:0] FUNC_REGISTER   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_CONNECT    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DISCONNECT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CHOOSE     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

    // Command token that walks the slot chain, gathering per-slot results.
    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        logic [PORT_W-1:0] port;
        logic [PORT_W-1:0] client;
        logic              done;     // register placed / connect or disconnect target found
        logic              any;      // choose saw at least one used slot
        logic [CNT_W-1:0]  hi;
        logic [CNT_W-1:0]  lo;
        logic [PORT_W-1:0] lo_port;
    } t_tok;

endpackage

// ===== sv/llpb_cell.sv =====
// One table slot: holds used bit, port and count, acts on the passing token.
`timescale 1ns / 1ps

module llpb_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  llpb_pkg::t_tok i_tok,
    output llpb_pkg::t_tok o_tok
);

    logic                          r_used;
    logic [llpb_pkg::PORT_W-1:0]   r_port;
    logic [llpb_pkg::CNT_W-1:0]    r_count;
    llpb_pkg::t_tok                r_tok;

    logic                          n_used;
    logic [llpb_pkg::PORT_W-1:0]   n_port;
    logic [llpb_pkg::CNT_W-1:0]    n_count;
    llpb_pkg::t_tok                n_tok;
    logic                          w_hit;

    assign w_hit = r_used && (r_port == i_tok.port) && !i_tok.done;

    always_comb begin
        n_used  = r_used;
        n_port  = r_port;
        n_count = r_count;
        n_tok   = i_tok;
        if (i_tok.valid) begin
            unique case (i_tok.func)
                llpb_pkg::FUNC_REGISTER: begin
                    if (!i_tok.done && !r_used) begin
                        n_used     = 1'b1;
                        n_port     = i_tok.port;
                        n_count    = '0;
                        n_tok.done = 1'b1;
                    end
                end
                llpb_pkg::FUNC_CONNECT: begin
                    if (w_hit) begin
                        n_tok.done = 1'b1;
                        if (r_count != llpb_pkg::CNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end
                llpb_pkg::FUNC_DISCONNECT: begin
                    if (w_hit) begin
                        n_tok.done = 1'b1;
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end
                end
                llpb_pkg::FUNC_CHOOSE: begin
                    if (r_used) begin
                        if (!i_tok.any) begin
                            n_tok.any     = 1'b1;
                            n_tok.hi      = r_count;
                            n_tok.lo      = r_count;
                            n_tok.lo_port = r_port;
                        end else begin
                            if (r_count > i_tok.hi) begin
                                n_tok.hi = r_count;
                            end
                            // strict compare keeps the first slot on ties
                            if (r_count < i_tok.lo) begin
                                n_tok.lo      = r_count;
                                n_tok.lo_port = r_port;
                            end
                        end
                    end
                end
                llpb_pkg::FUNC_CLEAR: begin
                    n_used = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // only the used bit and the token valid bit are reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_used  <= n_used;
            r_port  <= n_port;
            r_count <= n_count;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== sv/least_loaded_port_balancer_core.sv =====
// Top level of the least-loaded port balancer: input register, slot chain, result stage.
`timescale 1ns / 1ps

// Least-loaded port balancer. The port table is a chain of PORT_SLOTS cells,
// one slot per cell. Each command (register, connect, disconnect, choose,
// clear all) enters as a token that steps through the chain one cell per
// cycle; each cell updates its own slot and folds its count into the
// token's running max/min. Exactly one result item comes out per input item:
// chosen_port (nonzero only for choose) and status (1 when register found
// the table full). One item is in the chain at a time: an item passes
// through the input register, the cells, the pending register and the
// output register before its result is offered, and the slave side accepts
// the next item once the previous result has moved into the output register
// (even if that result has not been taken yet), so throughput is set by the
// walk through the slot chain. balance_gap is written through i_cfg_wen /
// i_cfg_wdata and should be changed only while the block is idle.

module least_loaded_port_balancer_core #(
    parameter int PORT_SLOTS = llpb_pkg::PORT_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // slave side
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [llpb_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // func[2:0], port[18:3], client_port[34:19]
    // master side
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [llpb_pkg::OUT_TDATA_W-1:0] o_m_tdata,   // chosen_port[15:0], status[16]
    // configuration
    input  logic                             i_cfg_wen,
    input  logic [llpb_pkg::CNT_W-1:0]       i_cfg_wdata  // balance_gap
);

    llpb_pkg::t_tok                 w_tok [PORT_SLOTS+1];
    llpb_pkg::t_tok                 r_in_tok;
    llpb_pkg::t_tok                 w_last;

    logic                           r_busy;
    logic [llpb_pkg::CNT_W-1:0]     r_gap;

    logic                           r_pend_valid;
    logic [llpb_pkg::PORT_W-1:0]    r_pend_port;
    logic                           r_pend_status;
    logic [llpb_pkg::PORT_W-1:0]    n_pend_port;
    logic                           n_pend_status;

    logic                           r_out_valid;
    logic [llpb_pkg::PORT_W-1:0]    r_out_port;
    logic                           r_out_status;

    logic                           w_in_acc;
    logic                           w_out_free;
    logic                           w_move;
    logic [llpb_pkg::CNT_W-1:0]     w_spread;

    assign o_s_tready = !r_busy;
    assign w_in_acc   = i_s_tvalid && !r_busy;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_move     = r_pend_valid && w_out_free;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= llpb_pkg::GAP_RESET;
        end else if (i_cfg_wen) begin
            r_gap <= i_cfg_wdata;
        end
    end

    // busy from acceptance until the result reaches the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_in_acc) begin
            r_busy <= 1'b1;
        end else if (w_move) begin
            r_busy <= 1'b0;
        end
    end

    // input register: unpack tdata into a fresh token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tok.valid <= 1'b0;
        end else begin
            r_in_tok.valid <= w_in_acc;
            if (w_in_acc) begin
                r_in_tok.func    <= i_s_tdata[2:0];
                r_in_tok.port    <= i_s_tdata[18:3];
                r_in_tok.client  <= i_s_tdata[34:19];
                r_in_tok.done    <= 1'b0;
                r_in_tok.any     <= 1'b0;
                r_in_tok.hi      <= '0;
                r_in_tok.lo      <= '0;
                r_in_tok.lo_port <= '0;
            end
        end
    end

    assign w_tok[0] = r_in_tok;

    for (genvar g = 0; g < PORT_SLOTS; g++) begin : g_cell
        llpb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last   = w_tok[PORT_SLOTS];
    assign w_spread = w_last.hi - w_last.lo;

    // result from the token leaving the last cell
    always_comb begin
        n_pend_port   = '0;
        n_pend_status = 1'b0;
        if (w_last.func == llpb_pkg::FUNC_CHOOSE) begin
            if (w_last.any && (w_spread >= r_gap)) begin
                n_pend_port = w_last.lo_port;
            end else begin
                n_pend_port = w_last.client;
            end
        end else if (w_last.func == llpb_pkg::FUNC_REGISTER) begin
            n_pend_status = !w_last.done;   // no free slot
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (w_last.valid) begin
            r_pend_valid <= 1'b1;
        end else if (w_move) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_last.valid) begin
            r_pend_port   <= n_pend_port;
            r_pend_status <= n_pend_status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_port   <= r_pend_port;
            r_out_status <= r_pend_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_status, r_out_port};

    // checks
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_busy)
        else $error("busy not set after accept");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |-> (r_busy && !r_pend_valid))
        else $error("token left chain while idle or result pending");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_busy)
        else $error("pending result while not busy");

    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (r_out_valid && !r_pend_valid))
        else $error("pending result not moved to output");

endmodule
